// File: design/tqb_pkg.sv
package tqb_pkg;

    // Result status codes
    typedef enum logic [3:0] {
        ST_SENT_DIRECT = 4'd0,
        ST_QUEUED      = 4'd1,
        ST_DISABLED    = 4'd2,
        ST_TOO_LARGE   = 4'd3,
        ST_FULL_DROP   = 4'd4,
        ST_EMPTY       = 4'd5,
        ST_BACKOFF     = 4'd6,
        ST_HW_BUSY     = 4'd7,
        ST_SENT_QUEUE  = 4'd8
    } t_status;

    // Sequencer states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Item kinds
    localparam logic FUNC_SEND  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION = 8'd1;
    localparam int CFG_DATA_W = 48;

    // Frame geometry
    localparam logic [15:0] HDR_BYTES = 16'd14;
    localparam logic [15:0] HDR_BELOW = 16'd78;
    localparam logic [15:0] MIN_FRAME = 16'd60;

endpackage

// File: design/tx_queue_with_backoff.sv
// Channel   | Direction | Signals                                         | Transfer
// ----------+-----------+-------------------------------------------------+-----------------------
// item      | in        | i_func i_payload_tag i_payload_length i_hw_ready | start && !busy
// result    | out       | o_status o_tx_* o_queue_depth o_dropped_count    | o_done (one cycle)
//           |           | o_room_available                                |
// config    | in        | i_cfg_index i_cfg_data                          | i_cfg_valid && o_cfg_ready
//
// For each item, the accept edge launches the read of the queue head from
// the entry RAM, the following cycle decides and writes back, and o_done pulses in the
// cycle after that, in which the next item may already be accepted.
// The registered read port of the entry RAM is why the decision waits for S_EXEC.
// Reset is synchronous and active low; busy and o_cfg_ready show it. No clearing pass.
// Register writes are held off while an item is offered or in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
module tx_queue_with_backoff
    import tqb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int RING_SIZE   = 8,
    parameter int MAX_PAYLOAD = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_func,
    input  logic [15:0]           i_payload_tag,
    input  logic [15:0]           i_payload_length,
    input  logic                  i_hw_ready,
    // result channel
    output logic                  o_done,
    output logic [3:0]            o_status,
    output logic                  o_tx_valid,
    output logic [15:0]           o_tx_tag,
    output logic [2:0]            o_tx_slot,
    output logic [7:0]            o_tx_frame_length,
    output logic                  o_tx_add_header,
    output logic [4:0]            o_queue_depth,
    output logic [31:0]           o_dropped_count,
    output logic                  o_room_available,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $clog2(RING_SIZE);
    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int EW = 16 + LW;

    // control state
    t_state        r_state, n_state;
    logic          r_enabled, n_enabled;
    logic [QW-1:0] r_head, n_head;
    logic [QW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_backoff, n_backoff;
    logic [31:0]   r_drops, n_drops;
    logic [RW-1:0] r_cursor, n_cursor;
    logic          r_done, n_done;

    // captured item
    logic          r_func;
    logic [15:0]   r_tag;
    logic [15:0]   r_len;
    logic          r_hw_ready;

    // result registers
    t_status       r_status, n_status;
    logic          r_tx_valid, n_tx_valid;
    logic [15:0]   r_tx_tag, n_tx_tag;
    logic [2:0]    r_tx_slot, n_tx_slot;
    logic [7:0]    r_tx_frame, n_tx_frame;
    logic          r_tx_hdr, n_tx_hdr;
    logic [4:0]    r_qdepth, n_qdepth;
    logic          r_room, n_room;

    // entry RAM
    logic          ram_we;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic          accept;
    logic          hand;
    logic [15:0]   hand_tag;
    logic [15:0]   hand_len;
    logic [15:0]   frame;
    logic [CW+4:0] qdepth_ext;
    logic [RW+2:0] slot_ext;

    assign accept      = start && !busy;
    assign busy        = !i_rst_n || (r_state != S_IDLE);
    // writes only land with nothing offered or in flight
    assign o_cfg_ready = !busy && !start;

    // head entry is read continuously; it is valid in S_EXEC
    tqb_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign ram_wdata = {r_tag, r_len[LW-1:0]};

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_enabled <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_backoff <= 1'b0;
            r_drops   <= '0;
            r_cursor  <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_enabled <= n_enabled;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_backoff <= n_backoff;
            r_drops   <= n_drops;
            r_cursor  <= n_cursor;
            r_done    <= n_done;
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func     <= i_func;
            r_tag      <= i_payload_tag;
            r_len      <= i_payload_length;
            r_hw_ready <= i_hw_ready;
        end
        if (r_state == S_EXEC) begin
            r_status   <= n_status;
            r_tx_valid <= n_tx_valid;
            r_tx_tag   <= n_tx_tag;
            r_tx_slot  <= n_tx_slot;
            r_tx_frame <= n_tx_frame;
            r_tx_hdr   <= n_tx_hdr;
            r_qdepth   <= n_qdepth;
            r_room     <= n_room;
        end
    end

    // configuration writes; a station address write is accepted but not stored
    always_comb begin
        n_enabled = r_enabled;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENABLED: n_enabled = i_cfg_data[0];
                CFG_STATION: n_enabled = r_enabled;
                default:     n_enabled = r_enabled;
            endcase
        end
    end

    // frame geometry of the handed-over frame
    assign hand_tag = (r_func == FUNC_DRAIN) ? ram_rdata[EW-1:LW] : r_tag;
    assign hand_len = (r_func == FUNC_DRAIN) ? 16'(ram_rdata[LW-1:0]) : r_len;

    always_comb begin
        frame = (hand_len < HDR_BELOW) ? hand_len + HDR_BYTES : hand_len;
        if (frame < MIN_FRAME) begin
            frame = MIN_FRAME;
        end
    end

    // sequencer: decide, update queue and counters
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_backoff = r_backoff;
        n_drops   = r_drops;
        n_cursor  = r_cursor;
        n_done    = 1'b0;
        n_status  = ST_DISABLED;
        ram_we    = 1'b0;
        hand      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (!r_enabled) begin
                    n_status = ST_DISABLED;
                end else if (r_func == FUNC_SEND) begin
                    if (r_len > 16'(MAX_PAYLOAD)) begin
                        n_status = ST_TOO_LARGE;
                    end else if (r_count == '0 && r_hw_ready) begin
                        hand     = 1'b1;
                        n_status = ST_SENT_DIRECT;
                    end else if (r_count >= CW'(QUEUE_DEPTH)) begin
                        n_drops  = r_drops + 32'd1;
                        n_status = ST_FULL_DROP;
                    end else begin
                        ram_we   = 1'b1;
                        n_tail   = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                        n_count  = r_count + 1'b1;
                        n_status = ST_QUEUED;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (r_backoff) begin
                        n_backoff = 1'b0;
                        n_status  = ST_BACKOFF;
                    end else if (!r_hw_ready) begin
                        n_backoff = 1'b1;
                        n_status  = ST_HW_BUSY;
                    end else begin
                        hand     = 1'b1;
                        n_head   = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        n_count  = r_count - 1'b1;
                        n_status = ST_SENT_QUEUE;
                    end
                end
                // every hand-over advances the ring and arms one backoff tick
                if (hand) begin
                    n_cursor  = (r_cursor == RW'(RING_SIZE - 1)) ? '0 : r_cursor + 1'b1;
                    n_backoff = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result fields
    assign qdepth_ext = {5'd0, n_count};
    assign slot_ext   = {3'd0, r_cursor};

    always_comb begin
        n_tx_valid = hand;
        n_tx_tag   = hand ? hand_tag : 16'd0;
        n_tx_slot  = hand ? slot_ext[2:0] : 3'd0;
        n_tx_frame = hand ? frame[7:0] : 8'd0;
        n_tx_hdr   = hand && (hand_len < HDR_BELOW);
        n_qdepth   = qdepth_ext[4:0];
        n_room     = n_count < CW'(QUEUE_DEPTH);
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_tx_valid        = r_tx_valid;
    assign o_tx_tag          = r_tx_tag;
    assign o_tx_slot         = r_tx_slot;
    assign o_tx_frame_length = r_tx_frame;
    assign o_tx_add_header   = r_tx_hdr;
    assign o_queue_depth     = r_qdepth;
    assign o_dropped_count   = r_drops;
    assign o_room_available  = r_room;

endmodule

// File: design/tqb_ram.sv
module tqb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: design/tqb_checker.sv
module tqb_checker
    import tqb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  i_func,
    input logic [15:0]           i_payload_tag,
    input logic [15:0]           i_payload_length,
    input logic                  i_hw_ready,
    input logic                  o_done,
    input logic [3:0]            o_status,
    input logic                  o_tx_valid,
    input logic [15:0]           o_tx_tag,
    input logic [2:0]            o_tx_slot,
    input logic [7:0]            o_tx_frame_length,
    input logic                  o_tx_add_header,
    input logic [4:0]            o_queue_depth,
    input logic [31:0]           o_dropped_count,
    input logic                  o_room_available,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // an accepted item keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_done)
        else $error("accepted item did not hold busy");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without work in progress");

    // transfer fields are zero when no frame goes to the ring
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_tx_valid |-> o_tx_tag == 16'd0 && o_tx_slot == 3'd0
            && o_tx_frame_length == 8'd0 && !o_tx_add_header)
        else $error("transfer fields set without a frame");

    // a frame goes out only with a send status and at least minimum length
    a_sent_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_tx_valid |-> (o_status == ST_SENT_DIRECT || o_status == ST_SENT_QUEUE)
            && o_tx_frame_length >= MIN_FRAME[7:0])
        else $error("frame with wrong status or short length");

    // the drop count moves only on a full-queue drop
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_FULL_DROP && $past(o_done, 2)
            |-> o_dropped_count == $past(o_dropped_count, 2))
        else $error("drop count changed without a drop");

endmodule

bind tx_queue_with_backoff tqb_checker u_tqb_checker (.*);
